// ===== hw/rtl/fdr_pkg.sv =====
package fdr_pkg;

  localparam int CosW    = 16;
  localparam int EtaW    = 15;
  localparam int CabsW   = 15;
  localparam int CiW     = 17;
  localparam int SqW     = 30;
  localparam int S2W     = 29;
  localparam int LhsW    = 59;
  localparam int ReflW   = 17;
  localparam int ProdW   = 32;

  localparam int DivNumW = 62;
  localparam int DivDenW = 33;
  localparam int DivQW   = 32;

  localparam int SqrtInW  = 33;
  localparam int SqrtResW = 17;

  localparam int RatioW  = 17;
  localparam int RatioSqW = 34;

  localparam logic signed [CosW-1:0] OneQ14    = 16'sd16384;
  localparam logic signed [CosW-1:0] NegOneQ14 = -16'sd16384;
  localparam logic [S2W-1:0]         OneQ28    = 29'h1000_0000;
  localparam logic [SqrtInW-1:0]     OneQ32    = 33'h1_0000_0000;
  localparam logic [ReflW-1:0]       OneQ16    = 17'h1_0000;

  typedef struct packed {
    logic signed [CosW-1:0] cos_incident;
    logic [EtaW-1:0]        eta_incident;
    logic [EtaW-1:0]        eta_transmit;
  } req_t;

  typedef struct packed {
    logic [ReflW-1:0] reflectance;
    logic             total_internal;
  } rsp_t;

  typedef struct packed {
    logic [EtaW-1:0] ei;
    logic [EtaW-1:0] et;
    logic [CiW-1:0]  ci;
    logic            tir;
  } tag_t;

  typedef struct packed {
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_args_t;

  function automatic div_args_t ratio_args(logic [ProdW-1:0] x, logic [ProdW-1:0] y);
    div_args_t       r;
    logic [DivDenW-1:0] den;
    logic [ProdW-1:0]   num;
    den = DivDenW'(x) + DivDenW'(y);
    num = (x >= y) ? (x - y) : (y - x);
    if (den == '0) begin
      r.num = DivNumW'(OneQ16);
      r.den = DivDenW'(1);
    end else begin
      r.num = {14'b0, num, 16'b0};
      r.den = den;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fresnel_dielectric_reflectance.sv =====
// Unpolarized Fresnel reflectance of a dielectric interface, fully pipelined: one request
// enters per cycle while the output is not stalled. The pipeline depth is set by two
// ranks of one-bit-per-stage restoring dividers (32 stages each: one for sin^2 of the
// transmitted angle, then two in parallel for the two amplitude ratios) and a 17-stage
// square root, plus seven arithmetic stages. A stall on the output freezes the whole
// pipeline and is passed to in_stall_o in the same cycle; nothing is dropped or repeated.
module fresnel_dielectric_reflectance (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fdr_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fdr_pkg::rsp_t  out_rsp_o
);

  logic en;

  logic                          fr_valid;
  logic [fdr_pkg::DivNumW-1:0]   fr_num;
  logic [fdr_pkg::DivDenW-1:0]   fr_den;
  fdr_pkg::tag_t                 fr_tag;

  logic                          sd_valid;
  logic [fdr_pkg::DivQW-1:0]     sd_quo;
  fdr_pkg::tag_t                 sd_tag;

  logic                          sq_valid;
  logic [fdr_pkg::SqrtResW-1:0]  sq_root;
  fdr_pkg::tag_t                 sq_tag;

  logic                          p_v_q;
  logic [fdr_pkg::ProdW-1:0]     a_q, b_q, p_q, q_q;
  fdr_pkg::tag_t                 p_tag_q;

  logic                          n_v_q;
  fdr_pkg::div_args_t            par_q, perp_q;
  fdr_pkg::tag_t                 n_tag_q;

  logic                          rp_valid, rs_valid;
  logic [fdr_pkg::DivQW-1:0]     rp_quo, rs_quo;
  fdr_pkg::tag_t                 rp_tag, rs_tag;

  logic                          s_v_q;
  logic [fdr_pkg::RatioSqW-1:0]  sqp_q, sqs_q;
  logic                          s_tir_q;

  logic                          out_valid_q;
  fdr_pkg::rsp_t                 out_q;

  logic [fdr_pkg::RatioSqW:0]    sum;
  logic [fdr_pkg::RatioSqW-17:0] rnd;
  fdr_pkg::rsp_t                 out_d;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  fdr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (fr_valid),
    .num_o   (fr_num),
    .den_o   (fr_den),
    .tag_o   (fr_tag)
  );

  fdr_div u_sin_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .tag_i   (fr_tag),
    .valid_o (sd_valid),
    .quo_o   (sd_quo),
    .tag_o   (sd_tag)
  );

  fdr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sd_valid),
    .rad_i   (fdr_pkg::OneQ32 - fdr_pkg::SqrtInW'(sd_quo)),
    .tag_i   (sd_tag),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q       <= 1'b0;
      n_v_q       <= 1'b0;
      s_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      p_v_q       <= sq_valid;
      n_v_q       <= p_v_q;
      s_v_q       <= rp_valid;
      out_valid_q <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= fdr_pkg::ProdW'(sq_tag.et) * fdr_pkg::ProdW'(sq_tag.ci);
      b_q     <= fdr_pkg::ProdW'(sq_tag.ei) * fdr_pkg::ProdW'(sq_root);
      p_q     <= fdr_pkg::ProdW'(sq_tag.ei) * fdr_pkg::ProdW'(sq_tag.ci);
      q_q     <= fdr_pkg::ProdW'(sq_tag.et) * fdr_pkg::ProdW'(sq_root);
      p_tag_q <= sq_tag;

      par_q   <= fdr_pkg::ratio_args(a_q, b_q);
      perp_q  <= fdr_pkg::ratio_args(p_q, q_q);
      n_tag_q <= p_tag_q;

      sqp_q   <= fdr_pkg::RatioSqW'(rp_quo[fdr_pkg::RatioW-1:0])
               * fdr_pkg::RatioSqW'(rp_quo[fdr_pkg::RatioW-1:0]);
      sqs_q   <= fdr_pkg::RatioSqW'(rs_quo[fdr_pkg::RatioW-1:0])
               * fdr_pkg::RatioSqW'(rs_quo[fdr_pkg::RatioW-1:0]);
      s_tir_q <= rp_tag.tir;

      out_q   <= out_d;
    end
  end

  fdr_div u_par_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n_v_q),
    .num_i   (par_q.num),
    .den_i   (par_q.den),
    .tag_i   (n_tag_q),
    .valid_o (rp_valid),
    .quo_o   (rp_quo),
    .tag_o   (rp_tag)
  );

  fdr_div u_perp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n_v_q),
    .num_i   (perp_q.num),
    .den_i   (perp_q.den),
    .tag_i   (n_tag_q),
    .valid_o (rs_valid),
    .quo_o   (rs_quo),
    .tag_o   (rs_tag)
  );

  always_comb begin
    sum = (fdr_pkg::RatioSqW + 1)'(sqp_q) + (fdr_pkg::RatioSqW + 1)'(sqs_q)
        + (fdr_pkg::RatioSqW + 1)'(17'h1_0000);
    rnd = sum[fdr_pkg::RatioSqW:17];
    if (s_tir_q) begin
      out_d.reflectance    = fdr_pkg::OneQ16;
      out_d.total_internal = 1'b1;
    end else begin
      out_d.total_internal = 1'b0;
      if (rnd > (fdr_pkg::RatioSqW - 16)'(fdr_pkg::OneQ16)) begin
        out_d.reflectance = fdr_pkg::OneQ16;
      end else begin
        out_d.reflectance = fdr_pkg::ReflW'(rnd);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  a_tir_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.total_internal) |-> (out_rsp_o.reflectance == fdr_pkg::OneQ16))
    else $error("total internal reflection without full reflectance");

  a_refl_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.reflectance <= fdr_pkg::OneQ16))
    else $error("reflectance above 1.0");

  a_div_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_valid == rs_valid)
    else $error("amplitude ratio dividers out of step");

  a_tag_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_valid |-> (rp_tag == rs_tag))
    else $error("amplitude ratio dividers carry different requests");
`endif

endmodule

// ===== hw/rtl/fdr_div.sv =====
module fdr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [fdr_pkg::DivNumW-1:0]  num_i,
  input  logic [fdr_pkg::DivDenW-1:0]  den_i,
  input  fdr_pkg::tag_t                tag_i,
  output logic                         valid_o,
  output logic [fdr_pkg::DivQW-1:0]    quo_o,
  output fdr_pkg::tag_t                tag_o
);

  localparam int QW = fdr_pkg::DivQW;
  localparam int NW = fdr_pkg::DivNumW;
  localparam int DW = fdr_pkg::DivDenW;
  localparam int W  = DW + QW;

  logic          v_q   [QW];
  logic          v_d   [QW];
  logic [NW-1:0] rem_q [QW];
  logic [NW-1:0] rem_d [QW];
  logic [DW-1:0] den_q [QW];
  logic [DW-1:0] den_d [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] quo_d [QW];
  fdr_pkg::tag_t tag_q [QW];
  fdr_pkg::tag_t tag_d [QW];

  always_comb begin
    logic [NW-1:0] rem_s;
    logic [DW-1:0] den_s;
    logic [QW-1:0] quo_s;
    logic [W-1:0]  trial;
    logic [W-1:0]  rem_x;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        v_d[k]   = valid_i;
        rem_s    = num_i;
        den_s    = den_i;
        quo_s    = '0;
        tag_d[k] = tag_i;
      end else begin
        v_d[k]   = v_q[k-1];
        rem_s    = rem_q[k-1];
        den_s    = den_q[k-1];
        quo_s    = quo_q[k-1];
        tag_d[k] = tag_q[k-1];
      end
      trial    = W'(den_s) << (QW - 1 - k);
      rem_x    = W'(rem_s);
      den_d[k] = den_s;
      if (rem_x >= trial) begin
        rem_d[k] = NW'(rem_x - trial);
        quo_d[k] = quo_s | (QW'(1) << (QW - 1 - k));
      end else begin
        rem_d[k] = rem_s;
        quo_d[k] = quo_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < QW; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_d[k];
        quo_q[k] <= quo_d[k];
        tag_q[k] <= tag_d[k];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// ===== hw/rtl/fdr_sqrt.sv =====
module fdr_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [fdr_pkg::SqrtInW-1:0]   rad_i,
  input  fdr_pkg::tag_t                 tag_i,
  output logic                          valid_o,
  output logic [fdr_pkg::SqrtResW-1:0]  root_o,
  output fdr_pkg::tag_t                 tag_o
);

  localparam int RW = fdr_pkg::SqrtResW;
  localparam int IW = fdr_pkg::SqrtInW;
  localparam int TW = 2 * RW + 1;

  logic          v_q   [RW];
  logic          v_d   [RW];
  logic [IW-1:0] rem_q [RW];
  logic [IW-1:0] rem_d [RW];
  logic [RW-1:0] res_q [RW];
  logic [RW-1:0] res_d [RW];
  fdr_pkg::tag_t tag_q [RW];
  fdr_pkg::tag_t tag_d [RW];

  always_comb begin
    logic [IW-1:0] rem_s;
    logic [RW-1:0] res_s;
    logic [TW-1:0] trial;
    logic [TW-1:0] rem_x;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        v_d[k]   = valid_i;
        rem_s    = rad_i;
        res_s    = '0;
        tag_d[k] = tag_i;
      end else begin
        v_d[k]   = v_q[k-1];
        rem_s    = rem_q[k-1];
        res_s    = res_q[k-1];
        tag_d[k] = tag_q[k-1];
      end
      trial = (TW'(res_s) << (RW - k)) + (TW'(1) << (2 * (RW - 1 - k)));
      rem_x = TW'(rem_s);
      if (rem_x >= trial) begin
        rem_d[k] = IW'(rem_x - trial);
        res_d[k] = res_s | (RW'(1) << (RW - 1 - k));
      end else begin
        rem_d[k] = rem_s;
        res_d[k] = res_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RW; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < RW; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RW; k++) begin
        rem_q[k] <= rem_d[k];
        res_q[k] <= res_d[k];
        tag_q[k] <= tag_d[k];
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = res_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

// ===== hw/rtl/fdr_front.sv =====
module fdr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  fdr_pkg::req_t                req_i,
  output logic                         valid_o,
  output logic [fdr_pkg::DivNumW-1:0]  num_o,
  output logic [fdr_pkg::DivDenW-1:0]  den_o,
  output fdr_pkg::tag_t                tag_o
);

  logic                          v1_q, v2_q, v3_q;
  logic [fdr_pkg::EtaW-1:0]      ei1_q, et1_q, ei2_q, et2_q;
  logic [fdr_pkg::CabsW-1:0]     cabs1_q, cabs2_q;
  logic [fdr_pkg::S2W-1:0]       csq1_q;
  logic [fdr_pkg::SqW-1:0]       eisq1_q, etsq1_q, etsq2_q;
  logic [fdr_pkg::LhsW-1:0]      lhs2_q;
  logic [fdr_pkg::DivNumW-1:0]   num3_q;
  logic [fdr_pkg::DivDenW-1:0]   den3_q;
  fdr_pkg::tag_t                 tag3_q;

  logic signed [fdr_pkg::CosW-1:0] cl;
  logic [fdr_pkg::CabsW-1:0]       cabs_d;
  logic [fdr_pkg::EtaW-1:0]        ei_d, et_d;
  logic [fdr_pkg::S2W-1:0]         s2;
  logic [fdr_pkg::LhsW-1:0]        rhs;
  logic                            tir;

  always_comb begin
    cl = req_i.cos_incident;
    if (cl > fdr_pkg::OneQ14) cl = fdr_pkg::OneQ14;
    if (cl < fdr_pkg::NegOneQ14) cl = fdr_pkg::NegOneQ14;
    if (cl <= 0) begin
      ei_d   = req_i.eta_transmit;
      et_d   = req_i.eta_incident;
      cabs_d = fdr_pkg::CabsW'(-cl);
    end else begin
      ei_d   = req_i.eta_incident;
      et_d   = req_i.eta_transmit;
      cabs_d = fdr_pkg::CabsW'(cl);
    end
  end

  assign s2  = fdr_pkg::OneQ28 - csq1_q;
  assign rhs = {1'b0, etsq2_q, 28'b0};
  assign tir = lhs2_q >= rhs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ei1_q   <= ei_d;
      et1_q   <= et_d;
      cabs1_q <= cabs_d;
      csq1_q  <= fdr_pkg::S2W'(fdr_pkg::SqW'(cabs_d) * fdr_pkg::SqW'(cabs_d));
      eisq1_q <= fdr_pkg::SqW'(ei_d) * fdr_pkg::SqW'(ei_d);
      etsq1_q <= fdr_pkg::SqW'(et_d) * fdr_pkg::SqW'(et_d);

      ei2_q   <= ei1_q;
      et2_q   <= et1_q;
      cabs2_q <= cabs1_q;
      etsq2_q <= etsq1_q;
      lhs2_q  <= fdr_pkg::LhsW'(eisq1_q) * fdr_pkg::LhsW'(s2);

      num3_q     <= tir ? '0 : {lhs2_q[fdr_pkg::LhsW-2:0], 4'b0};
      den3_q     <= tir ? fdr_pkg::DivDenW'(1) : fdr_pkg::DivDenW'(etsq2_q);
      tag3_q.ei  <= ei2_q;
      tag3_q.et  <= et2_q;
      tag3_q.ci  <= {cabs2_q, 2'b0};
      tag3_q.tir <= tir;
    end
  end

  assign valid_o = v3_q;
  assign num_o   = num3_q;
  assign den_o   = den3_q;
  assign tag_o   = tag3_q;

endmodule
